### rtl/rcgr_pkg.sv
// ============================================================================
// rcgr_pkg: shared types and constants for green highlight recovery
// Register map, configuration bundle, stage enables and fixed-point widths.
// ============================================================================
package rcgr_pkg;

	// Pipeline depth from the input beat to the output register.
	localparam int NUM_STAGES = 6;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;
	localparam int INV_BITS       = 24;
	localparam int LEVEL_BITS     = 16;

	// Fixed-point widths that do not depend on the pixel width.
	localparam int T_BITS  = 26; // clamped headroom, Q24
	localparam int WP_BITS = 42; // slope times headroom
	localparam int W_BITS  = 20; // signed blend weight, Q14

	// Reset values of the registers.
	localparam logic [INV_BITS-1:0]   RANGE_RECIP_RST  = 24'd256;
	localparam logic [LEVEL_BITS-1:0] LEVEL_RST        = 16'hFFFF;
	localparam logic [LEVEL_BITS-1:0] Q14_ONE          = 16'd16384;
	localparam logic [LEVEL_BITS-1:0] WEIGHT_SLOPE_RST = 16'd0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_RANGE_RECIP   = 3'd0,
		REG_BRIGHT_LEVEL  = 3'd1,
		REG_CLIP_RED      = 3'd2,
		REG_CLIP_BLUE     = 3'd3,
		REG_RECIP_RED     = 3'd4,
		REG_RECIP_BLUE    = 3'd5,
		REG_WEIGHT_BASE   = 3'd6,
		REG_WEIGHT_SLOPE  = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [INV_BITS-1:0]   range_recip;
		logic [LEVEL_BITS-1:0] bright_level;
		logic [LEVEL_BITS-1:0] clip_level_red;
		logic [LEVEL_BITS-1:0] clip_level_blue;
		logic [LEVEL_BITS-1:0] recip_factor_red;
		logic [LEVEL_BITS-1:0] recip_factor_blue;
		logic [LEVEL_BITS-1:0] weight_base;
		logic [LEVEL_BITS-1:0] weight_slope;
	} cfg_t;

	// Load enables, one per pipeline stage; s1 sits in the lowest bit.
	typedef struct packed {
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} stage_en_t;

endpackage

### rtl/rcgr_ctrl.sv
// ============================================================================
// rcgr_ctrl: pipeline flow control
// Tracks a valid bit per stage and lets each stage load when it is empty or
// when the stage after it moves on, so bubbles close up under a stall.
// ============================================================================
module rcgr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rcgr_pkg::stage_en_t   en
);

	localparam int N = rcgr_pkg::NUM_STAGES;

	logic [N-1:0] valid_q;
	logic [N-1:0] ready;
	logic [N-1:0] valid_in;

	always_comb begin
		ready[N-1] = !valid_q[N-1] || out_ready;
		for (int i = N - 2; i >= 0; i--) begin
			ready[i] = !valid_q[i] || ready[i+1];
		end
	end

	assign valid_in = {valid_q[N-2:0], in_valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int i = 0; i < N; i++) begin
				if (ready[i]) begin
					valid_q[i] <= valid_in[i];
				end
			end
		end
	end

	assign in_ready  = ready[0];
	assign out_valid = valid_q[N-1];
	assign en        = rcgr_pkg::stage_en_t'(ready);

endmodule

### rtl/rcgr_extrap.sv
// ============================================================================
// rcgr_extrap: products, recovery decision and headroom (stages 1 and 2)
// Scales red and blue by their reciprocal factors, measures how far the
// extrapolated green lies above the real one and clamps the headroom term.
// ============================================================================
module rcgr_extrap #(
	parameter int PIXEL_BITS       = 17,
	parameter int WEIGHT_CLAMP_Q14 = 16384
) (
	input  logic                            clk,
	input  rcgr_pkg::stage_en_t             en,
	input  rcgr_pkg::cfg_t                  cfg,
	input  logic signed [PIXEL_BITS-1:0]    red,
	input  logic signed [PIXEL_BITS-1:0]    green,
	input  logic signed [PIXEL_BITS-1:0]    blue,
	output logic [rcgr_pkg::T_BITS-1:0]     t_s2,
	output logic [PIXEL_BITS+17:0]          d_s2,
	output logic signed [PIXEL_BITS-1:0]    green_s2,
	output logic                            recov_s2
);

	localparam int PR_BITS  = PIXEL_BITS + 17;
	localparam int PG_BITS  = PIXEL_BITS + 25;
	localparam int SUM_BITS = PIXEL_BITS + 19;
	localparam int D_BITS   = PIXEL_BITS + 18;
	localparam int TF_BITS  = PIXEL_BITS + 26;
	localparam int T_BITS   = rcgr_pkg::T_BITS;

	localparam logic signed [TF_BITS-1:0] ONE_Q24 = TF_BITS'(1 << 24);
	localparam logic signed [TF_BITS-1:0] T_MAX_X = TF_BITS'(WEIGHT_CLAMP_Q14 * 1024);

	// Stage 1 inputs, widened for signed compares against unsigned levels.
	logic signed [PR_BITS-1:0]  red_x, green_x, blue_x;
	logic signed [PR_BITS-1:0]  bright_x, clip_r_x, clip_b_x;
	logic signed [16:0]         rf_x, bf_x;
	logic signed [24:0]         inv_x;
	logic signed [PR_BITS-1:0]  prod_r, prod_b;
	logic signed [PG_BITS-1:0]  prod_g;

	logic signed [PR_BITS-1:0]    prod_r_s1, prod_b_s1;
	logic signed [PG_BITS-1:0]    prod_g_s1;
	logic signed [PIXEL_BITS-1:0] green_s1;
	logic                         recov_s1;

	logic signed [SUM_BITS-1:0] diff;
	logic signed [TF_BITS-1:0]  t_full;
	logic [T_BITS-1:0]          t_clamp;
	logic [D_BITS-1:0]          d_pos;

	assign red_x    = PR_BITS'(red);
	assign green_x  = PR_BITS'(green);
	assign blue_x   = PR_BITS'(blue);
	assign bright_x = PR_BITS'(cfg.bright_level);
	assign clip_r_x = PR_BITS'(cfg.clip_level_red);
	assign clip_b_x = PR_BITS'(cfg.clip_level_blue);
	assign rf_x     = {1'b0, cfg.recip_factor_red};
	assign bf_x     = {1'b0, cfg.recip_factor_blue};
	assign inv_x    = {1'b0, cfg.range_recip};

	assign prod_r = red_x * rf_x;
	assign prod_b = blue_x * bf_x;
	assign prod_g = green * inv_x;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_r_s1 <= prod_r;
			prod_b_s1 <= prod_b;
			prod_g_s1 <= prod_g;
			green_s1  <= green;
			recov_s1  <= (green_x > bright_x) && ((red_x > clip_r_x) || (blue_x > clip_b_x));
		end
	end

	// The half in the mean of red and blue is folded into the 2^15 scale.
	assign diff = SUM_BITS'(prod_r_s1) + SUM_BITS'(prod_b_s1) - (SUM_BITS'(green_s1) <<< 15);
	assign d_pos = (diff > 0) ? D_BITS'(diff) : '0;

	assign t_full = ONE_Q24 - TF_BITS'(prod_g_s1);

	always_comb begin
		priority if (t_full < 0) begin
			t_clamp = '0;
		end else if (t_full > T_MAX_X) begin
			t_clamp = T_BITS'(T_MAX_X);
		end else begin
			t_clamp = T_BITS'(t_full);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			t_s2     <= t_clamp;
			d_s2     <= d_pos;
			green_s2 <= green_s1;
			recov_s2 <= recov_s1;
		end
	end

endmodule

### rtl/rcgr_weight.sv
// ============================================================================
// rcgr_weight: blend weight (stages 3 and 4)
// Multiplies the clamped headroom by the slope, rounds to Q14 and subtracts
// the result from the base weight.
// ============================================================================
module rcgr_weight #(
	parameter int PIXEL_BITS = 17
) (
	input  logic                                   clk,
	input  rcgr_pkg::stage_en_t                    en,
	input  rcgr_pkg::cfg_t                         cfg,
	input  logic [rcgr_pkg::T_BITS-1:0]            t_s2,
	input  logic [PIXEL_BITS+17:0]                 d_s2,
	input  logic signed [PIXEL_BITS-1:0]           green_s2,
	input  logic                                   recov_s2,
	output logic signed [rcgr_pkg::W_BITS-1:0]     w_s4,
	output logic [PIXEL_BITS+17:0]                 d_s4,
	output logic signed [PIXEL_BITS-1:0]           green_s4,
	output logic                                   recov_s4
);

	localparam int WP_BITS = rcgr_pkg::WP_BITS;
	localparam int W_BITS  = rcgr_pkg::W_BITS;
	localparam int D_BITS  = PIXEL_BITS + 18;

	localparam logic [WP_BITS:0] ROUND_HALF = (WP_BITS + 1)'(1 << 23);

	logic [WP_BITS-1:0]             wp_s3;
	logic [D_BITS-1:0]              d_s3;
	logic signed [PIXEL_BITS-1:0]   green_s3;
	logic                           recov_s3;

	logic [WP_BITS:0]               rnd_sum;
	logic [WP_BITS-24:0]            rnd;
	logic signed [W_BITS-1:0]       w_next;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			wp_s3    <= cfg.weight_slope * t_s2;
			d_s3     <= d_s2;
			green_s3 <= green_s2;
			recov_s3 <= recov_s2;
		end
	end

	assign rnd_sum = (WP_BITS + 1)'(wp_s3) + ROUND_HALF;
	assign rnd     = rnd_sum[WP_BITS:24];
	assign w_next  = W_BITS'(cfg.weight_base) - W_BITS'(rnd);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			w_s4     <= w_next;
			d_s4     <= d_s3;
			green_s4 <= green_s3;
			recov_s4 <= recov_s3;
		end
	end

endmodule

### rtl/rcgr_blend.sv
// ============================================================================
// rcgr_blend: weighted blend, rounding and saturation (stages 5 and 6)
// The weight times the excess is split into two partial products, which are
// summed with the scaled green, rounded, saturated and held for output.
// ============================================================================
module rcgr_blend #(
	parameter int PIXEL_BITS = 17
) (
	input  logic                                 clk,
	input  rcgr_pkg::stage_en_t                  en,
	input  logic signed [rcgr_pkg::W_BITS-1:0]   w_s4,
	input  logic [PIXEL_BITS+17:0]               d_s4,
	input  logic signed [PIXEL_BITS-1:0]         green_s4,
	input  logic                                 recov_s4,
	output logic signed [PIXEL_BITS-1:0]         green_out_s6,
	output logic                                 recov_s6
);

	localparam int W_BITS  = rcgr_pkg::W_BITS;
	localparam int D_BITS  = PIXEL_BITS + 18;
	localparam int LO_BITS = 24;
	localparam int HI_BITS = D_BITS - LO_BITS;
	localparam int PL_BITS = W_BITS + LO_BITS + 1;
	localparam int PH_BITS = W_BITS + HI_BITS + 1;
	localparam int AW      = PIXEL_BITS + 40;
	localparam int RW      = AW - 29;

	localparam logic signed [AW-1:0] ROUND_ACC = AW'(1 << 28);
	localparam logic signed [RW-1:0] PMAX      = RW'((1 << (PIXEL_BITS - 1)) - 1);
	localparam logic signed [RW-1:0] PMIN      = RW'(-(1 << (PIXEL_BITS - 1)));

	logic signed [LO_BITS:0]      d_lo_x;
	logic signed [HI_BITS:0]      d_hi_x;
	logic signed [PL_BITS-1:0]    p_lo_s5;
	logic signed [PH_BITS-1:0]    p_hi_s5;
	logic signed [PIXEL_BITS-1:0] green_s5;
	logic                         recov_s5;

	logic signed [AW-1:0]         acc;
	logic signed [RW-1:0]         res;
	logic signed [PIXEL_BITS-1:0] sat;

	assign d_lo_x = {1'b0, d_s4[LO_BITS-1:0]};
	assign d_hi_x = {1'b0, d_s4[D_BITS-1:LO_BITS]};

	always_ff @(posedge clk) begin
		if (en.s5) begin
			p_lo_s5  <= w_s4 * d_lo_x;
			p_hi_s5  <= w_s4 * d_hi_x;
			green_s5 <= green_s4;
			recov_s5 <= recov_s4;
		end
	end

	assign acc = (AW'(green_s5) <<< 29) + (AW'(p_hi_s5) <<< LO_BITS) + AW'(p_lo_s5) + ROUND_ACC;
	assign res = acc[AW-1:29];

	always_comb begin
		priority if (res > PMAX) begin
			sat = PIXEL_BITS'(PMAX);
		end else if (res < PMIN) begin
			sat = PIXEL_BITS'(PMIN);
		end else begin
			sat = PIXEL_BITS'(res);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			green_out_s6 <= recov_s5 ? sat : green_s5;
			recov_s6     <= recov_s5;
		end
	end

endmodule

### rtl/rgb_clipped_green_recovery.sv
// ============================================================================
// rgb_clipped_green_recovery: green highlight recovery for linear RGB pixels
// Replaces a bright green sample, where red or blue is clipped, by a blend
// toward the mean of the colour-corrected red and blue.
// ============================================================================
// Usage
// The input stream carries one pixel per beat on s_tdata: red, green and
// blue, each a signed sample of PIXEL_BITS bits, red in the lowest bits.
// The output stream carries the corrected green on m_tdata and a flag on
// m_tuser that is high when the blend was applied and low when green passed
// through unchanged. Exactly one output beat leaves for every input beat, in
// order.
// The pipeline has six register stages, the last of which is the output
// register, so an accepted beat moves through the stages in order and is
// held on m_tdata until the receiver takes it. One pixel is taken every
// cycle while the receiver keeps m_tready high, since every stage can then
// pass its beat on at each edge; the multipliers sit in stages 1, 3 and 5,
// which keeps the logic between registers short.
// When the receiver stalls, the stages behind it keep filling up any empty
// slots, so s_tready drops only once every stage holds a beat.
// The configuration registers are written through cfg_valid, cfg_index and
// cfg_data, which is never back-pressured. They should only be written while
// the pipeline is empty. Reset clears all valid bits and loads the register
// defaults, which at the default pixel width leave every pixel unchanged.
// ============================================================================
module rgb_clipped_green_recovery #(
	parameter int PIXEL_BITS       = 17,
	parameter int WEIGHT_CLAMP_Q14 = 16384
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0 up: red, green, blue, then zero padding.
	input  logic [((3*PIXEL_BITS+7)/8)*8-1:0]     s_tdata,

	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// Fields from bit 0 up: green_out, then zero padding.
	output logic [((PIXEL_BITS+7)/8)*8-1:0]       m_tdata,
	// Fields from bit 0 up: recovered.
	output logic                                  m_tuser,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rcgr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [rcgr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int OUT_BITS = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int D_BITS   = PIXEL_BITS + 18;
	localparam int LVL      = rcgr_pkg::LEVEL_BITS;

	rcgr_pkg::cfg_t      cfg_q;
	rcgr_pkg::stage_en_t en;

	logic signed [PIXEL_BITS-1:0] red, green, blue;

	logic [rcgr_pkg::T_BITS-1:0]         t_s2;
	logic [D_BITS-1:0]                   d_s2, d_s4;
	logic signed [PIXEL_BITS-1:0]        green_s2, green_s4, green_out_s6;
	logic                                recov_s2, recov_s4, recov_s6;
	logic signed [rcgr_pkg::W_BITS-1:0]  w_s4;

	// The register port is always able to take a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_recip       <= rcgr_pkg::RANGE_RECIP_RST;
			cfg_q.bright_level      <= rcgr_pkg::LEVEL_RST;
			cfg_q.clip_level_red    <= rcgr_pkg::LEVEL_RST;
			cfg_q.clip_level_blue   <= rcgr_pkg::LEVEL_RST;
			cfg_q.recip_factor_red  <= rcgr_pkg::Q14_ONE;
			cfg_q.recip_factor_blue <= rcgr_pkg::Q14_ONE;
			cfg_q.weight_base       <= rcgr_pkg::Q14_ONE;
			cfg_q.weight_slope      <= rcgr_pkg::WEIGHT_SLOPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rcgr_pkg::reg_index_t'(cfg_index))
				rcgr_pkg::REG_RANGE_RECIP: begin
					cfg_q.range_recip <= cfg_data[rcgr_pkg::INV_BITS-1:0];
				end
				rcgr_pkg::REG_BRIGHT_LEVEL: begin
					cfg_q.bright_level <= cfg_data[LVL-1:0];
				end
				rcgr_pkg::REG_CLIP_RED: begin
					cfg_q.clip_level_red <= cfg_data[LVL-1:0];
				end
				rcgr_pkg::REG_CLIP_BLUE: begin
					cfg_q.clip_level_blue <= cfg_data[LVL-1:0];
				end
				rcgr_pkg::REG_RECIP_RED: begin
					cfg_q.recip_factor_red <= cfg_data[LVL-1:0];
				end
				rcgr_pkg::REG_RECIP_BLUE: begin
					cfg_q.recip_factor_blue <= cfg_data[LVL-1:0];
				end
				rcgr_pkg::REG_WEIGHT_BASE: begin
					cfg_q.weight_base <= cfg_data[LVL-1:0];
				end
				rcgr_pkg::REG_WEIGHT_SLOPE: begin
					cfg_q.weight_slope <= cfg_data[LVL-1:0];
				end
			endcase
		end
	end

	// Unpack the pixel; the padding bits above blue are not used.
	assign red   = s_tdata[PIXEL_BITS-1:0];
	assign green = s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
	assign blue  = s_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];

	rcgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.en        (en)
	);

	// Stages 1 and 2: products, decision, excess of the extrapolated green
	// and clamped headroom.
	rcgr_extrap #(
		.PIXEL_BITS       (PIXEL_BITS),
		.WEIGHT_CLAMP_Q14 (WEIGHT_CLAMP_Q14)
	) u_extrap (
		.clk      (clk),
		.en       (en),
		.cfg      (cfg_q),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.t_s2     (t_s2),
		.d_s2     (d_s2),
		.green_s2 (green_s2),
		.recov_s2 (recov_s2)
	);

	// Stages 3 and 4: blend weight.
	rcgr_weight #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_weight (
		.clk      (clk),
		.en       (en),
		.cfg      (cfg_q),
		.t_s2     (t_s2),
		.d_s2     (d_s2),
		.green_s2 (green_s2),
		.recov_s2 (recov_s2),
		.w_s4     (w_s4),
		.d_s4     (d_s4),
		.green_s4 (green_s4),
		.recov_s4 (recov_s4)
	);

	// Stages 5 and 6: blend, rounding, saturation and the output register.
	rcgr_blend #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_blend (
		.clk          (clk),
		.en           (en),
		.w_s4         (w_s4),
		.d_s4         (d_s4),
		.green_s4     (green_s4),
		.recov_s4     (recov_s4),
		.green_out_s6 (green_out_s6),
		.recov_s6     (recov_s6)
	);

	assign m_tdata = OUT_BITS'($unsigned(green_out_s6));
	assign m_tuser = recov_s6;

`ifndef ASSERT_OFF
	// Once reset has been seen at an edge, nothing is presented in the
	// following cycle.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output beat valid after reset");

	// A receiver that is ready lets every stage move, so the input is ready.
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while the receiver is ready");

	// Without back-pressure an accepted beat passes through every stage and reaches the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_tvalid && s_tready, 6) && $past(m_tready, 1) && $past(m_tready, 2) &&
		$past(m_tready, 3) && $past(m_tready, 4) && $past(m_tready, 5) |-> m_tvalid)
		else $error("accepted beat did not arrive after six cycles");
`endif

endmodule

### sim/tb.sv
// ============================================================================
// tb: self-checking testbench for rgb_clipped_green_recovery
// A directed table followed by random phases. Each phase loads a new register
// setting through the configuration channel and then streams pixels. Both
// stream sides idle at random outside the steady phases. Each output beat
// is checked against a typed-in result or a model of the recovery arithmetic.
// ============================================================================
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIX_BITS         = 17;
	localparam int WEIGHT_CLAMP_Q14 = 16384;
	localparam int S_BITS           = ((3*PIX_BITS+7)/8)*8;
	localparam int M_BITS           = ((PIX_BITS+7)/8)*8;
	localparam int S_PAD            = S_BITS - 3*PIX_BITS;
	localparam int PIX_TOP          = (1 << (PIX_BITS-1)) - 1;
	localparam int INV_W            = rcgr_pkg::INV_BITS;
	localparam int LVL_W            = rcgr_pkg::LEVEL_BITS;
	localparam int CFG_W            = rcgr_pkg::CFG_DATA_BITS;
	localparam int IDX_W            = rcgr_pkg::CFG_INDEX_BITS;

	localparam longint PIX_MAX = (longint'(1) <<< (PIX_BITS-1)) - 1;
	localparam longint PIX_MIN = -(longint'(1) <<< (PIX_BITS-1));
	localparam longint T_CEIL  = longint'(WEIGHT_CLAMP_Q14) * 1024;

	// Register values straight after reset, in the order of cfg_t.
	localparam rcgr_pkg::cfg_t REGS_AT_RESET = '{rcgr_pkg::RANGE_RECIP_RST,
		rcgr_pkg::LEVEL_RST, rcgr_pkg::LEVEL_RST, rcgr_pkg::LEVEL_RST,
		rcgr_pkg::Q14_ONE, rcgr_pkg::Q14_ONE, rcgr_pkg::Q14_ONE,
		rcgr_pkg::WEIGHT_SLOPE_RST};

	typedef logic signed [PIX_BITS-1:0] pix_t;

	// One output beat: the green sample and whether the blend was applied.
	typedef struct packed {
		pix_t green;
		logic recovered;
	} green_est_t;

	typedef enum logic {ROW_PIX, ROW_REG} row_kind_t;

	// A row of the directed table is either a register write or a pixel. A pixel
	// row may carry its result typed in; otherwise the model predicts it.
	typedef struct packed {
		row_kind_t            kind;
		rcgr_pkg::reg_index_t idx;
		logic [CFG_W-1:0]     value;
		pix_t red;
		pix_t green;
		pix_t blue;
		logic typed;
		pix_t green_out;
		logic recovered;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [S_BITS-1:0]         s_tdata   = '0;
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [M_BITS-1:0]         m_tdata;
	logic                      m_tuser;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data  = '0;

	// Typed-in result that travels with the pixel currently on s_tdata.
	logic       row_typed = 1'b0;
	green_est_t row_est   = '0;

	rcgr_pkg::cfg_t shadow_regs = REGS_AT_RESET;
	green_est_t pending_green[$];
	green_est_t want, got;
	int unsigned fail_count = 0;
	int unsigned rx_hold    = 0;
	bit          steady     = 1'b0;

	stim_row_t directed_rows[$];

	rgb_clipped_green_recovery #(
		.PIXEL_BITS       (PIX_BITS),
		.WEIGHT_CLAMP_Q14 (WEIGHT_CLAMP_Q14)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Behavioural model of one pixel. The extrapolated green E and the scaled
	// green G share a 2^15 scale, the headroom t is Q24 and the weight is Q14,
	// so the final sum is scaled by 2^29 before rounding.
	function automatic green_est_t recover_green(pix_t red, pix_t green, pix_t blue,
			rcgr_pkg::cfg_t regs);
		longint r, g, b, e15, g15, m15, t24, w, acc, res;
		green_est_t est;
		r = red;
		g = green;
		b = blue;
		est.green     = green;
		est.recovered = 1'b0;
		// The levels are unsigned, so negative samples never count as bright
		// or clipped.
		if (g > longint'(regs.bright_level) &&
				(r > longint'(regs.clip_level_red) ||
				b > longint'(regs.clip_level_blue))) begin
			e15 = r * longint'(regs.recip_factor_red) +
				b * longint'(regs.recip_factor_blue);
			g15 = g * 32768;
			m15 = (e15 > g15) ? e15 : g15;
			t24 = (longint'(1) <<< 24) - g * longint'(regs.range_recip);
			if (t24 < 0) begin
				t24 = 0;
			end
			if (t24 > T_CEIL) begin
				t24 = T_CEIL;
			end
			// The weight may go negative; it is kept as it is and the
			// saturation below catches the overshoot.
			w = longint'(regs.weight_base) -
				((longint'(regs.weight_slope) * t24 + (longint'(1) <<< 23)) >>> 24);
			acc = g15 * 16384 + w * (m15 - g15) + (longint'(1) <<< 28);
			res = acc >>> 29;
			if (res > PIX_MAX) begin
				res = PIX_MAX;
			end
			if (res < PIX_MIN) begin
				res = PIX_MIN;
			end
			est.green     = pix_t'(res);
			est.recovered = 1'b1;
		end
		return est;
	endfunction

	// Idle length on either side: mostly none, sometimes short, rarely a long
	// stretch.
	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return 0;
		end else if (pick < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// A sample strictly above an unsigned level, or the top code if none is.
	function automatic pix_t above(int unsigned level);
		if (level >= PIX_TOP) begin
			return pix_t'(PIX_TOP);
		end
		return pix_t'($urandom_range(level + 1, PIX_TOP));
	endfunction

	// Values on and around the thresholds and the ends of the pixel range.
	function automatic pix_t boundary_pick(int unsigned level);
		case ($urandom_range(0, 6))
			0: return pix_t'(PIX_MIN);
			1: return pix_t'(-1);
			2: return pix_t'(0);
			3: return pix_t'(1);
			4: return pix_t'(PIX_TOP);
			5: return pix_t'(level);
			default: return pix_t'(level + 1);
		endcase
	endfunction

	// Register settings for the random phases. The first two phases take the
	// extremes; the rest lean towards settings that let recovery happen.
	function automatic rcgr_pkg::cfg_t pick_setting(int phase);
		rcgr_pkg::cfg_t s;
		if (phase == 0) begin
			s = '0;
		end else if (phase == 1) begin
			s = '1;
		end else begin
			case ($urandom_range(0, 5))
				0: s.range_recip = '0;
				1: s.range_recip = '1;
				2: s.range_recip = INV_W'($urandom);
				default: s.range_recip = INV_W'($urandom_range(128, 2048));
			endcase
			s.bright_level    = ($urandom_range(0, 9) == 0) ? '1 :
				LVL_W'($urandom_range(0, 50000));
			s.clip_level_red  = ($urandom_range(0, 9) == 0) ? '1 :
				LVL_W'($urandom_range(0, 60000));
			s.clip_level_blue = ($urandom_range(0, 9) == 0) ? '1 :
				LVL_W'($urandom_range(0, 60000));
			s.recip_factor_red  = ($urandom_range(0, 7) == 0) ? LVL_W'($urandom) :
				LVL_W'($urandom_range(4096, 40000));
			s.recip_factor_blue = ($urandom_range(0, 7) == 0) ? LVL_W'($urandom) :
				LVL_W'($urandom_range(4096, 40000));
			s.weight_base  = ($urandom_range(0, 7) == 0) ? LVL_W'($urandom) :
				LVL_W'($urandom_range(8192, 24576));
			case ($urandom_range(0, 3))
				0: s.weight_slope = '0;
				1: s.weight_slope = LVL_W'($urandom);
				default: s.weight_slope = LVL_W'($urandom_range(0, 16384));
			endcase
		end
		return s;
	endfunction

	// Most pixels are bright with red or blue clipped, so they reach the
	// blend; the rest are noise and values sitting on the thresholds.
	task automatic draw_pixel(output pix_t r, output pix_t g, output pix_t b);
		int unsigned mode;
		mode = $urandom_range(0, 9);
		r = pix_t'($urandom);
		g = pix_t'($urandom);
		b = pix_t'($urandom);
		if (mode == 2) begin
			r = boundary_pick(shadow_regs.clip_level_red);
			g = boundary_pick(shadow_regs.bright_level);
			b = boundary_pick(shadow_regs.clip_level_blue);
		end else if (mode > 2) begin
			g = above(shadow_regs.bright_level);
			case ($urandom_range(0, 2))
				0: r = above(shadow_regs.clip_level_red);
				1: b = above(shadow_regs.clip_level_blue);
				default: begin
					r = above(shadow_regs.clip_level_red);
					b = above(shadow_regs.clip_level_blue);
				end
			endcase
		end
	endtask

	// Presents one pixel beat and returns at the edge that accepts it. The
	// valid is only lowered when a gap is taken, so back-to-back beats keep it
	// high without a second assignment in the same step.
	task automatic send_pixel(pix_t r, pix_t g, pix_t b, logic typed, green_est_t est);
		int unsigned gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= {{S_PAD{1'b0}}, b, g, r};
		row_typed <= typed;
		row_est   <= est;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops the input stream and waits until every expected beat has left.
	// The first edge lets the last accepted beat land in the queue.
	task automatic await_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_green.size() != 0) @(posedge clk);
	endtask

	// Leaves cfg_valid high on return; the caller lowers it after a batch.
	task automatic write_reg(rcgr_pkg::reg_index_t idx, logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_setting(rcgr_pkg::cfg_t s);
		await_drain();
		write_reg(rcgr_pkg::REG_RANGE_RECIP,  s.range_recip);
		write_reg(rcgr_pkg::REG_BRIGHT_LEVEL, CFG_W'(s.bright_level));
		write_reg(rcgr_pkg::REG_CLIP_RED,     CFG_W'(s.clip_level_red));
		write_reg(rcgr_pkg::REG_CLIP_BLUE,    CFG_W'(s.clip_level_blue));
		write_reg(rcgr_pkg::REG_RECIP_RED,    CFG_W'(s.recip_factor_red));
		write_reg(rcgr_pkg::REG_RECIP_BLUE,   CFG_W'(s.recip_factor_blue));
		write_reg(rcgr_pkg::REG_WEIGHT_BASE,  CFG_W'(s.weight_base));
		write_reg(rcgr_pkg::REG_WEIGHT_SLOPE, CFG_W'(s.weight_slope));
		cfg_valid <= 1'b0;
	endtask

	// Receiver: random stalls of random length, none while the stream runs
	// steady.
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_hold  <= idle_len();
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watches all three channels at each edge. Register writes update the
	// model's copy of the registers, accepted pixels queue their expected beat
	// and output beats are compared with the oldest one in the queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_regs = REGS_AT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (rcgr_pkg::reg_index_t'(cfg_index))
					rcgr_pkg::REG_RANGE_RECIP:
						shadow_regs.range_recip = cfg_data;
					rcgr_pkg::REG_BRIGHT_LEVEL:
						shadow_regs.bright_level = cfg_data[LVL_W-1:0];
					rcgr_pkg::REG_CLIP_RED:
						shadow_regs.clip_level_red = cfg_data[LVL_W-1:0];
					rcgr_pkg::REG_CLIP_BLUE:
						shadow_regs.clip_level_blue = cfg_data[LVL_W-1:0];
					rcgr_pkg::REG_RECIP_RED:
						shadow_regs.recip_factor_red = cfg_data[LVL_W-1:0];
					rcgr_pkg::REG_RECIP_BLUE:
						shadow_regs.recip_factor_blue = cfg_data[LVL_W-1:0];
					rcgr_pkg::REG_WEIGHT_BASE:
						shadow_regs.weight_base = cfg_data[LVL_W-1:0];
					rcgr_pkg::REG_WEIGHT_SLOPE:
						shadow_regs.weight_slope = cfg_data[LVL_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (row_typed) begin
					pending_green.insert(pending_green.size(), row_est);
				end else begin
					pending_green.insert(pending_green.size(),
						recover_green(s_tdata[PIX_BITS-1:0],
						s_tdata[2*PIX_BITS-1:PIX_BITS], s_tdata[3*PIX_BITS-1:2*PIX_BITS],
						shadow_regs));
				end
			end
			if (m_tvalid && m_tready) begin
				got.green     = m_tdata[PIX_BITS-1:0];
				got.recovered = m_tuser;
				if (pending_green.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("tb: unexpected beat, green_out %0d recovered %0b",
							got.green, got.recovered);
					end
				end else begin
					want = pending_green.pop_front();
					if (got.green !== want.green || got.recovered !== want.recovered) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("tb: mismatch, green_out exp %0d got %0d, recovered exp %0b got %0b",
								want.green, got.green, want.recovered, got.recovered);
						end
					end
				end
			end
		end
	end

	initial begin
		pix_t r, g, b;
		bit reg_batch;
		reg_batch = 1'b0;

		// Fields: kind, register, value, red, green, blue, typed, green_out,
		// recovered.
		directed_rows = '{
			// Reset defaults put the bright level out of reach: all pass.
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 65535, 65535, 65535, 1, 65535, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, -65536, -65536, -65536, 1, -65536, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 0, 0, 0, 1, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 65535, -1, -65536, 1, -1, 0},
			// Zero thresholds with unit factors and unit weight: the output is
			// the larger of green and the red/blue mean.
			'{ROW_REG, rcgr_pkg::REG_BRIGHT_LEVEL, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_CLIP_RED, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_CLIP_BLUE, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 1000, 10, 2000, 1, 1500, 1},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 3000, 5000, 1000, 1, 5000, 1},
			// Green not above the level, and negative red and blue, pass.
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 100, 0, 100, 1, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, -5, 500, -7, 1, 500, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 65535, 65535, -65536, 0, 0, 0},
			// Negative weight: the output is pushed away from the estimate.
			'{ROW_REG, rcgr_pkg::REG_RANGE_RECIP, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_WEIGHT_BASE, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_WEIGHT_SLOPE, 65535, 0, 0, 0, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 65535, 100, 65535, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 65535, 65535, 65535, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 20000, 30000, 0, 0, 0, 0},
			// Top range reciprocal, red factor and weight base: the blend saturates high.
			'{ROW_REG, rcgr_pkg::REG_RANGE_RECIP, 24'hFFFFFF, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_CLIP_RED, 65534, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_CLIP_BLUE, 65535, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_RECIP_RED, 65535, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_RECIP_BLUE, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_WEIGHT_BASE, 65535, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_WEIGHT_SLOPE, 0, 0, 0, 0, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 65535, 1, 0, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 65534, 1, 65535, 1, 1, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 65535, 2, -65536, 0, 0, 0},
			// A mid-range setting, probed on either side of each threshold.
			'{ROW_REG, rcgr_pkg::REG_RANGE_RECIP, 256, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_BRIGHT_LEVEL, 1000, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_CLIP_RED, 30000, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_CLIP_BLUE, 30000, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_RECIP_RED, 16384, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_RECIP_BLUE, 16384, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_WEIGHT_BASE, 16384, 0, 0, 0, 0, 0, 0},
			'{ROW_REG, rcgr_pkg::REG_WEIGHT_SLOPE, 16384, 0, 0, 0, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 30001, 1000, 0, 1, 1000, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 30001, 1001, 0, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 0, 40000, 30001, 0, 0, 0},
			'{ROW_PIX, rcgr_pkg::REG_RANGE_RECIP, 0, 30000, 50000, 30000, 1, 50000, 0}
		};

		// Reset is held from the start and released at a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. A run of register rows is written as one batch,
		// only once the pipeline has drained.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				if (!reg_batch) begin
					await_drain();
					reg_batch = 1'b1;
				end
				write_reg(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				if (reg_batch) begin
					cfg_valid <= 1'b0;
					reg_batch = 1'b0;
				end
				send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
					directed_rows[i].typed,
					'{green: directed_rows[i].green_out, recovered: directed_rows[i].recovered});
			end
		end

		// Random phases, each with its own setting. Every fourth phase runs
		// without idling on either side, and one phase stops half way until
		// all of its results are out.
		for (int phase = 0; phase < 9; phase++) begin
			load_setting(pick_setting(phase));
			steady = (phase % 4 == 3);
			for (int n = 0; n < 50; n++) begin
				draw_pixel(r, g, b);
				send_pixel(r, g, b, 1'b0, '0);
				if (phase == 5 && n == 25) begin
					await_drain();
				end
			end
		end
		steady = 1'b0;

		// Let the pipeline empty, then give a stray beat time to appear.
		await_drain();
		repeat (rcgr_pkg::NUM_STAGES + 4) @(posedge clk);
		if (pending_green.size() != 0) begin
			$display("tb: %0d results never arrived", pending_green.size());
			fail_count += pending_green.size();
		end
		if (fail_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
